// ----- design/connection_timeout_heap_unit_assert.svh -----
// Assertion macros for the timeout heap unit.
`ifndef CONNECTION_TIMEOUT_HEAP_UNIT_ASSERT_SVH
`define CONNECTION_TIMEOUT_HEAP_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define CTH_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);
`define CTH_ASSERT_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);
`else
`define CTH_ASSERT(lbl, ck, rs, prop, msg)
`define CTH_ASSERT_ALWAYS(lbl, ck, prop, msg)
`endif

`endif

// ----- design/cth_pkg.sv -----
`default_nettype none
package cth_pkg;

  localparam int SLOTS_DEF     = 64;
  localparam int TIME_BITS_DEF = 48;

  localparam int CMD_W      = 2;
  localparam int SLOT_W     = 6;
  localparam int TIMEOUT_W  = 31;
  localparam int NOW_W      = 48;
  localparam int S_TDATA_W  = 88;
  localparam int M_TDATA_W  = 8;

  localparam logic [CMD_W-1:0] CMD_ADD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_MARK = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK = 2'd2;

  typedef struct packed {
    logic load;
    logic add;
    logic mark;
    logic scan_start;
    logic scan;
    logic close;
    logic stale;
    logic req_wr;
    logic finish;
  } cth_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] op;
    logic             scan_last;
    logic             best_valid;
    logic             handle;
    logic             best_cur;
    logic             best_present;
    logic             held_valid;
    logic             out_free;
  } cth_sts_t;

endpackage
`default_nettype wire

// ----- design/cth_dpath.sv -----
`default_nettype none
`include "connection_timeout_heap_unit_assert.svh"
module cth_dpath #(
  parameter int SLOTS     = cth_pkg::SLOTS_DEF,
  parameter int TIME_BITS = cth_pkg::TIME_BITS_DEF
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire  cth_pkg::cth_cmd_t         cmd,
  output cth_pkg::cth_sts_t               sts,
  input  wire  [cth_pkg::CMD_W-1:0]       op_in,
  input  wire  [cth_pkg::SLOT_W-1:0]      slot_in,
  input  wire  [cth_pkg::TIMEOUT_W-1:0]   timeout_in,
  input  wire  [cth_pkg::NOW_W-1:0]       now_in,
  output logic                            m_valid,
  input  wire                             m_ready,
  output logic [cth_pkg::SLOT_W-1:0]      m_slot,
  output logic                            m_last
);
  import cth_pkg::*;

  localparam int IDX_W = $clog2(SLOTS);

  logic [CMD_W-1:0]     op_q;
  logic [SLOT_W-1:0]    slot_q;
  logic [TIMEOUT_W-1:0] timeout_q;
  logic [TIME_BITS-1:0] now_q;

  logic [TIME_BITS:0]   sum_w;
  logic [TIME_BITS-1:0] deadline_new;
  logic                 slot_ok;
  logic [IDX_W-1:0]     add_idx;

  logic [SLOTS-1:0] present;
  logic [SLOTS-1:0] queued;
  logic [SLOTS-1:0] qcur;
  logic [SLOTS-1:0] deleted;

  logic [TIME_BITS-1:0] cur_mem [SLOTS];
  logic [TIME_BITS-1:0] qdl_mem [SLOTS];
  logic [TIME_BITS-1:0] cur_rdata;
  logic [TIME_BITS-1:0] qdl_rdata;
  logic                 qdl_we;
  logic [IDX_W-1:0]     qdl_waddr;
  logic [TIME_BITS-1:0] qdl_wdata;

  logic [IDX_W-1:0]     scan_idx;
  logic                 pipe_v;
  logic [IDX_W-1:0]     pipe_idx;
  logic                 best_valid;
  logic [IDX_W-1:0]     best_slot;
  logic [TIME_BITS-1:0] best_dl;

  logic              held_valid;
  logic [IDX_W-1:0]  held_slot;
  logic              out_free;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q      <= op_in;
      slot_q    <= slot_in;
      timeout_q <= timeout_in;
      now_q     <= TIME_BITS'(now_in);
    end
  end

  assign sum_w        = {1'b0, now_q} + (TIME_BITS+1)'(timeout_q);
  assign deadline_new = sum_w[TIME_BITS] ? '1 : sum_w[TIME_BITS-1:0];
  assign slot_ok      = ({1'b0, slot_q} < (SLOT_W+1)'(SLOTS));
  assign add_idx      = slot_q[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      present <= '0;
      queued  <= '0;
      qcur    <= '0;
      deleted <= '0;
    end else begin
      if (cmd.add && slot_ok) begin
        present[add_idx] <= 1'b1;
        if (!queued[add_idx]) begin
          queued[add_idx] <= 1'b1;
          qcur[add_idx]   <= 1'b1;
        end else begin
          qcur[add_idx] <= 1'b0;
        end
      end
      if (cmd.mark && slot_ok) begin
        deleted[add_idx] <= 1'b1;
      end
      if (cmd.close) begin
        queued[best_slot]  <= 1'b0;
        qcur[best_slot]    <= 1'b0;
        present[best_slot] <= 1'b0;
        deleted[best_slot] <= 1'b0;
      end
      if (cmd.stale) begin
        queued[best_slot] <= 1'b0;
      end
      if (cmd.req_wr) begin
        queued[best_slot] <= 1'b1;
        qcur[best_slot]   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add && slot_ok) begin
      cur_mem[add_idx] <= deadline_new;
    end
    cur_rdata <= cur_mem[best_slot];
  end

  assign qdl_we    = (cmd.add && slot_ok && !queued[add_idx]) || cmd.req_wr;
  assign qdl_waddr = cmd.req_wr ? best_slot : add_idx;
  assign qdl_wdata = cmd.req_wr ? cur_rdata : deadline_new;

  always_ff @(posedge clk) begin
    if (qdl_we) begin
      qdl_mem[qdl_waddr] <= qdl_wdata;
    end
    qdl_rdata <= qdl_mem[scan_idx];
  end

  always_ff @(posedge clk) begin
    pipe_idx <= scan_idx;
    if (rst) begin
      scan_idx   <= '0;
      pipe_v     <= 1'b0;
      best_valid <= 1'b0;
    end else if (cmd.scan_start) begin
      scan_idx   <= '0;
      pipe_v     <= 1'b0;
      best_valid <= 1'b0;
    end else begin
      pipe_v <= cmd.scan;
      if (cmd.scan) begin
        scan_idx <= scan_idx + 1'b1;
      end
      if (pipe_v && queued[pipe_idx] && (!best_valid || qdl_rdata < best_dl)) begin
        best_valid <= 1'b1;
        best_slot  <= pipe_idx;
        best_dl    <= qdl_rdata;
      end
    end
  end

  assign out_free = !m_valid || m_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      m_valid    <= 1'b0;
    end else begin
      if (m_valid && m_ready) begin
        m_valid <= 1'b0;
      end
      if (cmd.close) begin
        if (held_valid) begin
          m_valid <= 1'b1;
          m_slot  <= SLOT_W'(held_slot);
          m_last  <= 1'b0;
        end
        held_valid <= 1'b1;
        held_slot  <= best_slot;
      end
      if (cmd.finish) begin
        if (held_valid) begin
          m_valid <= 1'b1;
          m_slot  <= SLOT_W'(held_slot);
          m_last  <= 1'b1;
        end
        held_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    sts.op           = op_q;
    sts.scan_last    = (scan_idx == IDX_W'(SLOTS - 1));
    sts.best_valid   = best_valid;
    sts.handle       = deleted[best_slot] || (now_q >= best_dl);
    sts.best_cur     = qcur[best_slot];
    sts.best_present = present[best_slot];
    sts.held_valid   = held_valid;
    sts.out_free     = out_free;
  end

  `CTH_ASSERT(a_cur_needs_queued, clk, rst, (qcur & ~queued) == '0, "current flag without entry")
  `CTH_ASSERT(a_queued_needs_present, clk, rst, (queued & ~present) == '0, "entry without deadline")
  `CTH_ASSERT(a_push_into_free, clk, rst, cmd.close && held_valid |-> out_free, "closure overwrote item")

endmodule
`default_nettype wire

// ----- design/cth_ctrl.sv -----
`default_nettype none
`include "connection_timeout_heap_unit_assert.svh"
module cth_ctrl (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     s_valid,
  output logic                    s_ready,
  input  wire  cth_pkg::cth_sts_t sts,
  output cth_pkg::cth_cmd_t       cmd
);
  import cth_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_TAIL   = 3'd3;
  localparam logic [2:0] S_DECIDE = 3'd4;
  localparam logic [2:0] S_REQ    = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign s_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (sts.op)
          CMD_ADD: begin
            cmd.add    = 1'b1;
            state_next = S_IDLE;
          end
          CMD_MARK: begin
            cmd.mark   = 1'b1;
            state_next = S_IDLE;
          end
          CMD_TICK: begin
            cmd.scan_start = 1'b1;
            state_next     = S_SCAN;
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) begin
          state_next = S_TAIL;
        end
      end
      S_TAIL: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (!sts.best_valid || !sts.handle) begin
          state_next = S_FINISH;
        end else if (sts.best_cur) begin
          if (!sts.held_valid || sts.out_free) begin
            cmd.close      = 1'b1;
            cmd.scan_start = 1'b1;
            state_next     = S_SCAN;
          end
        end else begin
          cmd.stale = 1'b1;
          if (sts.best_present) begin
            state_next = S_REQ;
          end else begin
            cmd.scan_start = 1'b1;
            state_next     = S_SCAN;
          end
        end
      end
      S_REQ: begin
        cmd.req_wr     = 1'b1;
        cmd.scan_start = 1'b1;
        state_next     = S_SCAN;
      end
      S_FINISH: begin
        if (!sts.held_valid || sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `CTH_ASSERT(a_idle_nothing_held, clk, rst, state == S_IDLE |-> !sts.held_valid, "held closure in idle")
  `CTH_ASSERT(a_close_is_due, clk, rst, cmd.close |-> sts.best_valid && sts.handle && sts.best_cur, "bad closure")
  `CTH_ASSERT(a_requeue_after_stale, clk, rst, cmd.req_wr |-> $past(cmd.stale), "requeue without stale entry")

endmodule
`default_nettype wire

// ----- design/connection_timeout_heap_unit.sv -----
// Add and mark items: accepted, applied in the next cycle, after which the unit is ready again.
// Tick items: each examined entry costs a full scan of all slots (one read of the
// queued-deadline memory per slot, a pipeline step, a decision), plus one requeue
// step per stale entry requeued, and a tick waits while the output is stalled.
// A closure is held until the next closure is found; the last waits for tick end.
// Reset clears all per-slot flags at once; deadline memories are not cleared.
`default_nettype none
module connection_timeout_heap_unit #(
  parameter int SLOTS     = cth_pkg::SLOTS_DEF,
  parameter int TIME_BITS = cth_pkg::TIME_BITS_DEF
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire  [cth_pkg::S_TDATA_W-1:0]    s_axis_tdata,  // slot, timeout_ms, now_ms, pad
  input  wire  [cth_pkg::CMD_W-1:0]        s_axis_tuser,  // cmd
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  output logic [cth_pkg::M_TDATA_W-1:0]    m_axis_tdata,  // closed_slot, pad
  output logic                             m_axis_tlast
);
  import cth_pkg::*;

  cth_cmd_t          cmd;
  cth_sts_t          sts;
  logic [SLOT_W-1:0] closed_slot;

  cth_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  cth_dpath #(
    .SLOTS     (SLOTS),
    .TIME_BITS (TIME_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .op_in      (s_axis_tuser),
    .slot_in    (s_axis_tdata[SLOT_W-1:0]),
    .timeout_in (s_axis_tdata[SLOT_W +: TIMEOUT_W]),
    .now_in     (s_axis_tdata[SLOT_W+TIMEOUT_W +: NOW_W]),
    .m_valid    (m_axis_tvalid),
    .m_ready    (m_axis_tready),
    .m_slot     (closed_slot),
    .m_last     (m_axis_tlast)
  );

  assign m_axis_tdata = M_TDATA_W'(closed_slot);

endmodule
`default_nettype wire

// ----- tb/connection_timeout_heap_unit_test.sv -----
`default_nettype none
module connection_timeout_heap_unit_test;
  import cth_pkg::*;

  localparam int N_SLOTS        = SLOTS_DEF;
  localparam int MAX_GAP        = 17;
  localparam int RANDOM_ITEMS   = 320;
  // a tick that requeues every slot without closing any: about 65 full scans
  localparam int DRAIN_CYCLES   = 4500;
  localparam int WATCHDOG_LIMIT = 25000;
  localparam logic [CMD_W-1:0]     CMD_NOP  = 2'd3;
  localparam logic [NOW_W-1:0]     NOW_MAX  = '1;
  localparam logic [TIMEOUT_W-1:0] TOUT_MAX = '1;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              last;
  } closure_t;

  class timeout_heap_scoreboard;
    bit             present[N_SLOTS];
    bit             queued[N_SLOTS];
    bit             q_current[N_SLOTS];
    bit             del_mark[N_SLOTS];
    bit [NOW_W-1:0] q_deadline[N_SLOTS];
    bit [NOW_W-1:0] cur_deadline[N_SLOTS];
    closure_t       closures_due[$];
    int             errors;
    int             closures;
    int             ticks;
    int             requeues;

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    function void note_item(logic [CMD_W-1:0] cmd, logic [SLOT_W-1:0] slot,
                            logic [TIMEOUT_W-1:0] timeout, logic [NOW_W-1:0] now);
      logic [NOW_W:0] sum;
      int             best;
      int             n;
      closure_t       c;
      case (cmd)
        CMD_ADD: begin
          sum = {1'b0, now} + {{(NOW_W + 1 - TIMEOUT_W){1'b0}}, timeout};
          cur_deadline[slot] = sum[NOW_W] ? NOW_MAX : sum[NOW_W-1:0];
          present[slot] = 1'b1;
          if (!queued[slot]) begin
            queued[slot] = 1'b1;
            q_deadline[slot] = cur_deadline[slot];
            q_current[slot] = 1'b1;
          end else begin
            q_current[slot] = 1'b0;
          end
        end
        CMD_MARK: del_mark[slot] = 1'b1;
        CMD_TICK: begin
          ticks++;
          n = 0;
          for (int g = 0; g < 2 * N_SLOTS + 2; g++) begin
            best = -1;
            for (int s = 0; s < N_SLOTS; s++)
              if (queued[s] && (best < 0 || q_deadline[s] < q_deadline[best])) best = s;
            if (best < 0) break;
            if (!(del_mark[best] || now >= q_deadline[best])) break;
            queued[best] = 1'b0;
            if (q_current[best]) begin
              q_current[best] = 1'b0;
              present[best] = 1'b0;
              del_mark[best] = 1'b0;
              c.slot = best[SLOT_W-1:0];
              c.last = 1'b0;
              closures_due.push_back(c);
              n++;
            end else if (present[best]) begin
              queued[best] = 1'b1;
              q_deadline[best] = cur_deadline[best];
              q_current[best] = 1'b1;
              requeues++;
            end
          end
          if (n > 0) closures_due[closures_due.size() - 1].last = 1'b1;
        end
        default: ;
      endcase
    endfunction

    task check_result(logic [SLOT_W-1:0] slot, logic last);
      closure_t e;
      if (closures_due.size() == 0) begin
        report($sformatf("closure of slot %0d with none pending", slot));
        return;
      end
      e = closures_due.pop_front();
      closures++;
      if (slot !== e.slot) report($sformatf("closed_slot %0d, predicted %0d", slot, e.slot));
      if (last !== e.last)
        report($sformatf("last %b on slot %0d, predicted %b", last, slot, e.last));
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  wire                  s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic [CMD_W-1:0]     s_axis_tuser = '0;
  wire                  m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  wire  [M_TDATA_W-1:0] m_axis_tdata;
  wire                  m_axis_tlast;

  timeout_heap_scoreboard sb = new();
  bit             tx_burst = 1'b0;
  bit             rx_burst = 1'b0;
  int             rx_hold = 0;
  int             idle_cycles = 0;
  int             random_sent = 0;
  logic [NOW_W-1:0] clock_ms = '0;

  connection_timeout_heap_unit uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [NOW_W-1:0] rand_now();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[NOW_W-1:0];
  endfunction

  function automatic logic [TIMEOUT_W-1:0] rand_timeout();
    logic [31:0] v;
    v = $urandom;
    return v[TIMEOUT_W-1:0];
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(logic [CMD_W-1:0] cmd, logic [SLOT_W-1:0] slot,
                           logic [TIMEOUT_W-1:0] timeout, logic [NOW_W-1:0] now);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = cmd;
    s_axis_tdata  = {3'b000, now, timeout, slot};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_item(cmd, slot, timeout, now);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    while (sb.closures_due.size() != 0) @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (rx_hold > 0) begin
      m_axis_tready = 1'b0;
      rx_hold--;
    end else begin
      m_axis_tready = 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata[SLOT_W-1:0], m_axis_tlast);
      if ($urandom_range(0, 99) < 3) rx_burst = !rx_burst;
      rx_hold = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", idle_cycles);
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int                   pick;
    int                   sel;
    logic [SLOT_W-1:0]    slot;
    logic [TIMEOUT_W-1:0] timeout;
    logic [NOW_W-1:0]     now;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: zero deadline, saturation, refresh, ties, marks, unused command
    send_item(CMD_ADD,  6'd0,  '0, '0);
    send_item(CMD_ADD,  6'd63, TOUT_MAX, NOW_MAX);
    send_item(CMD_ADD,  6'd5,  31'd100, 48'd0);
    send_item(CMD_ADD,  6'd5,  31'd300, 48'd50);
    send_item(CMD_ADD,  6'd6,  31'd100, 48'd0);
    send_item(CMD_ADD,  6'd7,  31'd1000, 48'd0);
    send_item(CMD_MARK, 6'd7,  '0, '0);
    send_item(CMD_MARK, 6'd9,  TOUT_MAX, NOW_MAX);
    send_item(CMD_NOP,  6'd1,  rand_timeout(), rand_now());
    send_item(CMD_TICK, 6'd0,  '0, 48'd0);
    send_item(CMD_TICK, 6'd0,  '0, 48'd100);
    send_item(CMD_TICK, 6'd0,  '0, 48'd1000);
    send_item(CMD_ADD,  6'd9,  31'd5000, 48'd1000);
    send_item(CMD_TICK, 6'd9,  '0, 48'd1000);
    send_item(CMD_TICK, 6'd0,  '0, NOW_MAX);
    send_item(CMD_ADD,  6'd10, 31'd0, NOW_MAX - 48'd1);
    send_item(CMD_ADD,  6'd11, TOUT_MAX, 48'd0);
    send_item(CMD_TICK, 6'd0,  '0, 48'd0);
    send_item(CMD_TICK, 6'd0,  '0, NOW_MAX);
    send_item(CMD_TICK, 6'd0,  '0, 48'd5);
    wait_drained();

    while (random_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 99) < 3) tx_burst = !tx_burst;
      if ($urandom_range(0, 99) < 4) wait_drained();
      pick = $urandom_range(0, 99);
      slot = SLOT_W'($urandom_range(0, N_SLOTS - 1));
      if (pick < 45) begin
        sel = $urandom_range(0, 9);
        if (sel < 7) timeout = TIMEOUT_W'($urandom_range(0, 300));
        else if (sel < 9) timeout = rand_timeout();
        else timeout = $urandom_range(0, 1) ? TOUT_MAX : '0;
        now = ($urandom_range(0, 19) == 0) ? rand_now() : clock_ms;
        send_item(CMD_ADD, slot, timeout, now);
        random_sent++;
      end else if (pick < 60) begin
        send_item(CMD_MARK, slot, rand_timeout(), rand_now());
        random_sent++;
      end else if (pick < 90) begin
        clock_ms = clock_ms + $urandom_range(0, 150);
        send_item(CMD_TICK, slot, rand_timeout(), clock_ms);
        random_sent++;
      end else if (pick < 95) begin
        sel = $urandom_range(0, 2);
        if (sel == 0) begin
          clock_ms = rand_now();
          now = clock_ms;
        end else if (sel == 1) begin
          clock_ms = NOW_MAX - $urandom_range(0, 500);
          now = clock_ms;
        end else begin
          now = NOW_MAX;
        end
        send_item(CMD_TICK, slot, rand_timeout(), now);
        random_sent++;
      end else begin
        send_item(CMD_NOP, slot, rand_timeout(), rand_now());
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("summary: 20 directed and %0d random items, %0d ticks, %0d closures checked",
             random_sent, sb.ticks, sb.closures);
    $display("summary: %0d stale entries requeued, %0d mismatches", sb.requeues, sb.errors);
    if (sb.errors == 0 && sb.closures_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- sim.f -----
+incdir+design
design/cth_pkg.sv
design/cth_dpath.sv
design/cth_ctrl.sv
design/connection_timeout_heap_unit.sv
tb/connection_timeout_heap_unit_test.sv
